[rtl/core/range_fill_deque_unit_defines.svh]
// ----------------------------------------------------------------------------
// Range fill deque - assertion macros
// Shared assertion shorthands, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_FILL_DEQUE_UNIT_DEFINES_SVH
`define RANGE_FILL_DEQUE_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define RFD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define RFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  `RFD_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define RFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RFD_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

[rtl/core/rfd_pkg.sv]
// ----------------------------------------------------------------------------
// Range fill deque - package
// Operation and status codes, stream field layout and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

  // Fixed field widths of the stream items.
  localparam int MODE_W    = 3;
  localparam int FIELD_W   = 16;
  localparam int RCOUNT_W  = 7;
  localparam int OCC_W     = 7;
  localparam int STATUS_W  = 2;

  // Input tdata layout, lowest bit first.
  localparam int IN_MODE_LSB   = 0;
  localparam int IN_START_LSB  = IN_MODE_LSB + MODE_W;
  localparam int IN_STEP_LSB   = IN_START_LSB + FIELD_W;
  localparam int IN_END_LSB    = IN_STEP_LSB + FIELD_W;
  localparam int IN_RCOUNT_LSB = IN_END_LSB + FIELD_W;
  localparam int IN_USED_W     = IN_RCOUNT_LSB + RCOUNT_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata carries value then occupancy; tuser carries empty then status.
  localparam int OUT_USED_W    = FIELD_W + OCC_W;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_USED_W;
  localparam int OUT_TUSER_W   = 1 + STATUS_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_FRONT = 3'd0,
    MODE_ADD_BACK  = 3'd1,
    MODE_REM_FRONT = 3'd2,
    MODE_REM_BACK  = 3'd3,
    MODE_DUMP      = 3'd4
  } rfd_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_REM_IGNORED  = 2'd1,
    STATUS_PUSH_DROPPED = 2'd2
  } rfd_status_e;

  // Control into the range generator.
  typedef struct packed {
    logic               load;
    logic               advance;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] step;
    logic [FIELD_W-1:0] stop;
  } rfd_gen_ctrl_t;

  // Status out of the range generator.
  typedef struct packed {
    logic               in_range;
    logic [FIELD_W-1:0] value;
  } rfd_gen_stat_t;

endpackage

`default_nettype wire

[rtl/core/range_fill_deque_unit.sv]
// ----------------------------------------------------------------------------
// Range fill deque unit
// Bounded double-ended queue in a ring buffer, driven by range-add, remove
// and dump operations, with one result transfer per operation or entry.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Signals                          Carries
//  s_*      in   tvalid tready tdata[63:0]        one operation per transfer
//  m_*      out  tvalid tready tdata tlast tuser  one result per transfer
//
// A range add pushes its values one at a time, as they come from the
// shared adder and compare of the range generator. A dump issues one
// store read per cycle and so delivers one entry per cycle while the
// output is taken. A remove passes through the remove and response
// states; an unused code or a dump of an empty queue goes straight to
// the response state. The slave side is ready only while the sequencer
// is idle; the output register lets the last result of one operation
// wait while the next is accepted. There is no clearing pass after
// reset: only occupied entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module range_fill_deque_unit #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // [2:0] mode, [18:3] range_start, [34:19] range_step,
  // [50:35] range_end, [57:51] remove_count, [63:58] zero
  input  logic [rfd_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // [15:0] value, [22:16] occupancy, [23] zero
  output logic [rfd_pkg::OUT_TDATA_W-1:0]   m_tdata_o,
  // [0] queue_empty, [2:1] status
  output logic [rfd_pkg::OUT_TUSER_W-1:0]   m_tuser_o,
  // last_item
  output logic                              m_tlast_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i
);
  import rfd_pkg::*;

  `include "range_fill_deque_unit_defines.svh"

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_REMOVE,
    S_DUMP,
    S_RESP
  } state_e;

  // Ring position of the entry at the given distance from the front.
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [PW:0] sum;
    sum = (PW+1)'(base) + (PW+1)'(off);
    if (sum >= (PW+1)'(DEPTH)) begin
      sum = sum - (PW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  // Input unpacking.
  rfd_mode_e            in_mode;
  logic [FIELD_W-1:0]   in_start, in_step, in_stop;
  logic [RCOUNT_W-1:0]  in_rcount;

  assign in_mode   = rfd_mode_e'(s_tdata_i[IN_MODE_LSB +: MODE_W]);
  assign in_start  = s_tdata_i[IN_START_LSB +: FIELD_W];
  assign in_step   = s_tdata_i[IN_STEP_LSB +: FIELD_W];
  assign in_stop   = s_tdata_i[IN_END_LSB +: FIELD_W];
  assign in_rcount = s_tdata_i[IN_RCOUNT_LSB +: RCOUNT_W];

  // Sequencer and queue state.
  state_e               state_q,    state_d;
  logic [PW-1:0]        front_q,    front_d;
  logic [CW-1:0]        count_q,    count_d;
  logic                 at_front_q, at_front_d;
  logic [RCOUNT_W-1:0]  rcount_q,   rcount_d;
  rfd_status_e          status_q,   status_d;
  logic                 empty_q,    empty_d;
  logic [CW-1:0]        issue_q,    issue_d;
  logic [CW-1:0]        left_q,     left_d;
  logic                 rd_pend_q,  rd_pend_d;

  // Output register.
  logic                 out_valid_q,  out_valid_d;
  logic [FIELD_W-1:0]   out_value_q,  out_value_d;
  logic                 out_last_q,   out_last_d;
  logic                 out_empty_q,  out_empty_d;
  rfd_status_e          out_status_q, out_status_d;
  logic [OCC_W-1:0]     out_occ_q,    out_occ_d;

  // Store and generator hookup.
  logic                   wr_en;
  logic [PW-1:0]          wr_addr;
  logic                   rd_en;
  logic [PW-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  rfd_gen_ctrl_t          gen_ctrl;
  rfd_gen_stat_t          gen_stat;

  logic s_accept;
  logic can_load;
  logic dump_load;
  logic dump_issue;
  logic [PW-1:0] front_dec;

  assign s_tready_o = (state_q == S_IDLE);
  assign s_accept   = s_tvalid_i && s_tready_o;
  assign can_load   = !out_valid_q || m_tready_i;
  assign front_dec  = (front_q == '0) ? PW'(DEPTH - 1) : front_q - 1'b1;

  // Dump pipeline: one read in flight, moved to the output when it is free.
  assign dump_load  = (state_q == S_DUMP) && rd_pend_q && can_load;
  assign dump_issue = (state_q == S_DUMP) && (issue_q < count_q) &&
                      (!rd_pend_q || dump_load);

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    at_front_d   = at_front_q;
    rcount_d     = rcount_q;
    status_d     = status_q;
    empty_d      = empty_q;
    issue_d      = issue_q;
    left_d       = left_q;
    rd_pend_d    = rd_pend_q;

    out_valid_d  = out_valid_q && !m_tready_i;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;

    wr_en            = 1'b0;
    wr_addr          = slot_of(front_q, count_q);
    gen_ctrl.load    = s_accept;
    gen_ctrl.advance = 1'b0;
    gen_ctrl.start   = in_start;
    gen_ctrl.step    = in_step;
    gen_ctrl.stop    = in_stop;
    rd_en            = dump_issue;
    rd_addr          = slot_of(front_q, issue_q);

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          at_front_d = (in_mode == MODE_ADD_FRONT) || (in_mode == MODE_REM_FRONT);
          rcount_d   = in_rcount;
          status_d   = STATUS_OK;
          empty_d    = 1'b0;
          unique case (in_mode) inside
            MODE_ADD_FRONT, MODE_ADD_BACK: begin
              state_d = S_FILL;
            end
            MODE_REM_FRONT, MODE_REM_BACK: begin
              state_d = S_REMOVE;
            end
            MODE_DUMP: begin
              if (count_q == '0) begin
                empty_d = 1'b1;
                state_d = S_RESP;
              end else begin
                issue_d = '0;
                left_d  = count_q;
                state_d = S_DUMP;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_FILL: begin
        // One value per cycle until the range is spent or the queue fills.
        if (!gen_stat.in_range) begin
          state_d = S_RESP;
        end else if (count_q == CW'(DEPTH)) begin
          status_d = STATUS_PUSH_DROPPED;
          state_d  = S_RESP;
        end else begin
          wr_en            = 1'b1;
          gen_ctrl.advance = 1'b1;
          count_d          = count_q + 1'b1;
          if (at_front_q) begin
            wr_addr = front_dec;
            front_d = front_dec;
          end
        end
      end

      S_REMOVE: begin
        if ((count_q == '0) || (rcount_q > OCC_W'(count_q))) begin
          status_d = STATUS_REM_IGNORED;
        end else begin
          count_d = count_q - CW'(rcount_q);
          if (at_front_q) begin
            front_d = slot_of(front_q, CW'(rcount_q));
          end
        end
        state_d = S_RESP;
      end

      S_DUMP: begin
        if (dump_issue) begin
          issue_d = issue_q + 1'b1;
        end
        rd_pend_d = dump_issue || (rd_pend_q && !dump_load);
        if (dump_load) begin
          out_valid_d  = 1'b1;
          out_value_d  = FIELD_W'(rd_data);
          out_last_d   = (left_q == CW'(1));
          out_empty_d  = 1'b0;
          out_status_d = STATUS_OK;
          out_occ_d    = OCC_W'(count_q);
          left_d       = left_q - 1'b1;
          if (left_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          out_empty_d  = empty_q;
          out_status_d = status_q;
          out_occ_d    = OCC_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    at_front_q   <= at_front_d;
    rcount_q     <= rcount_d;
    status_q     <= status_d;
    empty_q      <= empty_d;
    issue_q      <= issue_d;
    left_q       <= left_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
    out_empty_q  <= out_empty_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  rfd_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (VALUE_WIDTH'(gen_stat.value)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  rfd_range_gen u_gen (
    .clk_i  (clk_i),
    .ctrl_i (gen_ctrl),
    .stat_o (gen_stat)
  );

  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {{OUT_PAD_W{1'b0}}, out_occ_q, out_value_q};
  assign m_tuser_o  = {out_status_q, out_empty_q};

  // The entry count never runs past the ring size.
  `RFD_ASSERT_CLK(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
  // A store write only happens with room left, and grows the count by one.
  `RFD_ASSERT_IMPL(a_write_room, wr_en, count_q < CW'(DEPTH), "write into a full queue")
  `RFD_ASSERT_NEXT(a_write_count, wr_en, count_q == $past(count_q) + 1'b1, "count not bumped")
  // No dump read may be in flight once the sequencer is idle again.
  `RFD_ASSERT_IMPL(a_idle_no_read, s_tready_o, !rd_pend_q && !rd_en, "read left in flight")
  // Read data waiting for the output is never overwritten.
  `RFD_ASSERT_NEXT(a_read_held, rd_pend_q && !dump_load, rd_pend_q && $stable(rd_data), "read data lost")

endmodule

`default_nettype wire

[rtl/core/rfd_store.sv]
// ----------------------------------------------------------------------------
// Range fill deque - entry store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_store #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  logic [VALUE_WIDTH-1:0]       wr_data_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_i,
  output logic [VALUE_WIDTH-1:0]       rd_data_o
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/core/rfd_range_gen.sv]
// ----------------------------------------------------------------------------
// Range fill deque - range generator
// Shared adder and compare that steps through start, start+step, ... end.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_range_gen (
  input  logic                  clk_i,
  input  rfd_pkg::rfd_gen_ctrl_t ctrl_i,
  output rfd_pkg::rfd_gen_stat_t stat_o
);
  import rfd_pkg::*;

  // One guard bit so that a step past the top of the range is still seen.
  logic [FIELD_W:0]   acc_q,  acc_d;
  logic [FIELD_W-1:0] step_q, step_d;
  logic [FIELD_W-1:0] stop_q, stop_d;

  always_comb begin
    acc_d  = acc_q;
    step_d = step_q;
    stop_d = stop_q;
    if (ctrl_i.load) begin
      acc_d  = {1'b0, ctrl_i.start};
      // A zero step behaves as a step of one.
      step_d = (ctrl_i.step == '0) ? FIELD_W'(1) : ctrl_i.step;
      stop_d = ctrl_i.stop;
    end else if (ctrl_i.advance) begin
      acc_d  = acc_q + {1'b0, step_q};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    step_q <= step_d;
    stop_q <= stop_d;
  end

  assign stat_o.in_range = (acc_q <= {1'b0, stop_q});
  assign stat_o.value    = acc_q[FIELD_W-1:0];

endmodule

`default_nettype wire

[tb/range_fill_deque_unit_tb.sv]
// ----------------------------------------------------------------------------
// Range fill deque unit - testbench
// Drives range-add, remove, dump and unused operations into the slave stream
// and checks every result transfer against a local model of the ring-buffer
// deque, under several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module range_fill_deque_unit_tb;

  import rfd_pkg::*;

  localparam int QDEPTH      = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 80;

  // One result transfer as the model expects it.
  typedef struct packed {
    logic [FIELD_W-1:0]  value;
    logic [OCC_W-1:0]    occupancy;
    logic                pad;
    logic                is_last;
    logic                empty;
    logic [STATUS_W-1:0] status;
  } deque_result_t;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata_i  = '0;
  logic                   s_tvalid_i = 1'b0;
  logic                   s_tready_o;
  logic [OUT_TDATA_W-1:0] m_tdata_o;
  logic [OUT_TUSER_W-1:0] m_tuser_o;
  logic                   m_tlast_o;
  logic                   m_tvalid_o;
  logic                   m_tready_i = 1'b0;

  // Model state: entry store, front index and fill level.
  logic [FIELD_W-1:0]     q_store [QDEPTH];
  logic [5:0]             q_head = '0;
  logic [OCC_W-1:0]       q_fill = '0;

  deque_result_t          pending_results [$];
  int                     err_cnt   = 0;
  int                     cycle_cnt = 0;
  int                     src_idle_pct  = 0;
  int                     snk_stall_pct = 0;

  range_fill_deque_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i)
  );

  always #2 clk_i = ~clk_i;

  // The run is abandoned if it goes on far longer than any correct run could.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Every accepted result transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    deque_result_t got, want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = '{value: m_tdata_o[15:0], occupancy: m_tdata_o[22:16], pad: m_tdata_o[23],
              is_last: m_tlast_o, empty: m_tuser_o[0], status: m_tuser_o[2:1]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer value=%h occ=%0d last=%b empty=%b st=%0d",
                 $time, got.value, got.occupancy, got.is_last, got.empty, got.status);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected value=%h occ=%0d pad=%b last=%b empty=%b st=%0d",
                   $time, want.value, want.occupancy, want.pad, want.is_last, want.empty,
                   want.status);
          $display("%0t:          actual   value=%h occ=%0d pad=%b last=%b empty=%b st=%0d",
                   $time, got.value, got.occupancy, got.pad, got.is_last, got.empty,
                   got.status);
          err_cnt++;
        end
      end
    end
  end

  // Pushes the values start, start+step, ... up to stop into the model while room
  // lasts, at the front one at a time so the last value ends up first, else at the back.
  function automatic logic [STATUS_W-1:0] model_add_range(bit at_front, int unsigned start,
                                                          int unsigned step,
                                                          int unsigned stop);
    int unsigned n, room, k;
    if (step == 0) step = 1;
    if (start > stop) return STATUS_OK;
    n    = (stop - start) / step + 1;
    room = QDEPTH - q_fill;
    k    = (n < room) ? n : room;
    for (int unsigned j = 0; j < k; j++) begin
      if (at_front) begin
        q_head = q_head - 6'd1;
        q_store[q_head] = 16'(start + j * step);
      end else begin
        q_store[6'(q_head + q_fill[5:0])] = 16'(start + j * step);
      end
      q_fill++;
    end
    return (n > room) ? STATUS_PUSH_DROPPED : STATUS_OK;
  endfunction

  // Works out the results of one accepted operation and queues them.
  function automatic void model_operation(logic [MODE_W-1:0] mode, logic [15:0] start,
                                          logic [15:0] step, logic [15:0] stop,
                                          logic [RCOUNT_W-1:0] rcount);
    logic [STATUS_W-1:0] st;
    st = STATUS_OK;
    case (mode) inside
      MODE_ADD_FRONT: st = model_add_range(1'b1, 32'(start), 32'(step), 32'(stop));
      MODE_ADD_BACK:  st = model_add_range(1'b0, 32'(start), 32'(step), 32'(stop));
      MODE_REM_FRONT, MODE_REM_BACK: begin
        if (q_fill == 0 || rcount > q_fill) begin
          st = STATUS_REM_IGNORED;
        end else begin
          if (mode == MODE_REM_FRONT) q_head = q_head + rcount[5:0];
          q_fill = q_fill - rcount;
        end
      end
      MODE_DUMP: begin
        if (q_fill == 0) begin
          pending_results.push_back('{value: '0, occupancy: '0, pad: 1'b0, is_last: 1'b1,
                                      empty: 1'b1, status: STATUS_OK});
        end else begin
          for (int i = 0; i < q_fill; i++) begin
            pending_results.push_back('{value: q_store[6'(q_head + i)], occupancy: q_fill,
                                        pad: 1'b0, is_last: (i + 1 == q_fill), empty: 1'b0,
                                        status: STATUS_OK});
          end
        end
        return;
      end
      default: ; // unused codes leave the queue alone
    endcase
    pending_results.push_back('{value: '0, occupancy: q_fill, pad: 1'b0, is_last: 1'b1,
                                empty: 1'b0, status: st});
  endfunction

  // Offers one operation, idling first as the phase asks, and returns at the
  // edge of its transfer with tvalid still high.
  task automatic send_op(logic [MODE_W-1:0] mode, logic [15:0] start, logic [15:0] step,
                         logic [15:0] stop, logic [RCOUNT_W-1:0] rcount);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tdata_i  <= {6'b0, rcount, stop, step, start, mode};
    s_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_tready_o);
    model_operation(mode, start, step, stop, rcount);
  endtask

  // Holds the sender off until every expected result has been taken.
  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(int src_pct, int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // Removes and dumps on an empty queue, then simple adds at both ends,
  // an empty range, a step of zero and values at the top of the range.
  task automatic test_basic_ops();
    send_op(MODE_DUMP, 16'h0, 16'h0, 16'h0, 7'd0);
    send_op(MODE_REM_FRONT, 16'h0, 16'h0, 16'h0, 7'd0);
    send_op(MODE_REM_BACK, 16'h0, 16'h0, 16'h0, 7'd1);
    send_op(MODE_ADD_BACK, 16'd0, 16'd0, 16'd3, 7'd0);
    send_op(MODE_ADD_FRONT, 16'd65530, 16'd2, 16'hFFFF, 7'd0);
    send_op(MODE_ADD_BACK, 16'd10, 16'd1, 16'd5, 7'd0);
    send_op(MODE_DUMP, 16'h0, 16'h0, 16'h0, 7'd0);
    send_op(MODE_ADD_BACK, 16'h0, 16'hFFFF, 16'hFFFF, 7'd0);
    send_op(MODE_ADD_FRONT, 16'h5555, 16'hAAAA, 16'hFFFF, 7'd0);
    send_op(MODE_DUMP, 16'h0, 16'h0, 16'h0, 7'd0);
  endtask

  // Removes of zero, of too many, and from each end; unused mode codes.
  task automatic test_removes_and_unused();
    send_op(MODE_REM_FRONT, 16'h0, 16'h0, 16'h0, 7'd0);
    send_op(MODE_REM_BACK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F);
    send_op(MODE_REM_FRONT, 16'h0, 16'h0, 16'h0, 7'd2);
    send_op(MODE_REM_BACK, 16'h0, 16'h0, 16'h0, 7'd1);
    for (int m = 5; m < 8; m++) begin
      send_op(3'(m), 16'($urandom), 16'($urandom), 16'($urandom), 7'($urandom));
    end
  endtask

  // Fills the queue to the brim, dumps all of it, overfills, empties it with
  // an exact remove, then overfills from the front and empties from the back.
  task automatic test_full_queue();
    send_op(MODE_ADD_BACK, 16'd0, 16'd1, 16'hFFFF, 7'd0);
    send_op(MODE_DUMP, 16'h0, 16'h0, 16'h0, 7'd0);
    send_op(MODE_ADD_FRONT, 16'd1, 16'd1, 16'd1, 7'd0);
    send_op(MODE_REM_FRONT, 16'h0, 16'h0, 16'h0, 7'd64);
    send_op(MODE_REM_BACK, 16'h0, 16'h0, 16'h0, 7'd64);
    send_op(MODE_ADD_FRONT, 16'd100, 16'd3, 16'd400, 7'd0);
    send_op(MODE_REM_BACK, 16'h0, 16'h0, 16'h0, 7'd65);
    send_op(MODE_REM_BACK, 16'h0, 16'h0, 16'h0, 7'd64);
  endtask

  // Mostly well-formed adds, removes and dumps with random content, a share
  // of broken removes and empty ranges, and a little pure noise.
  task automatic test_random_traffic(int n_items);
    int unsigned pick, start, step, len, stop;
    logic [MODE_W-1:0] mode;
    for (int i = 0; i < n_items; i++) begin
      pick  = $urandom_range(99);
      start = $urandom_range(16'hFFFF);
      step  = ($urandom_range(9) < 7) ? $urandom_range(9) : $urandom_range(16'hFFFF);
      len   = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(12);
      stop  = start + ((step == 0) ? 1 : step) * len;
      if (stop > 16'hFFFF) stop = 16'hFFFF;
      if ($urandom_range(19) == 0 && start > 0) stop = $urandom_range(start - 1);
      if (pick < 22) begin
        send_op(MODE_ADD_FRONT, 16'(start), 16'(step), 16'(stop), 7'($urandom));
      end else if (pick < 44) begin
        send_op(MODE_ADD_BACK, 16'(start), 16'(step), 16'(stop), 7'($urandom));
      end else if (pick < 72) begin
        mode = ($urandom_range(1) == 0) ? MODE_REM_FRONT : MODE_REM_BACK;
        send_op(mode, 16'($urandom), 16'($urandom), 16'($urandom),
                ($urandom_range(3) != 0) ? 7'($urandom_range(q_fill))
                                         : 7'($urandom_range(127)));
      end else if (pick < 90) begin
        send_op(MODE_DUMP, 16'($urandom), 16'($urandom), 16'($urandom), 7'($urandom));
      end else if (pick < 95) begin
        send_op(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom), 16'($urandom),
                7'($urandom));
      end else begin
        send_op(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    test_basic_ops();
    test_removes_and_unused();
    test_full_queue();

    // Random traffic in four phases; the sender waits for every result
    // between phases.
    test_random_traffic(40);
    drain_results();
    set_idling(57, 0);
    test_random_traffic(40);
    drain_results();
    set_idling(0, 57);
    test_random_traffic(40);
    drain_results();
    set_idling(20, 20);
    test_random_traffic(40);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
